### rtl/core/leaky_spiking_neuron_array_assert.svh
// ----------------------------------------------------------------------------
// leaky_spiking_neuron_array assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LEAKY_SPIKING_NEURON_ARRAY_ASSERT_SVH
`define LEAKY_SPIKING_NEURON_ARRAY_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define LSNA_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lsna assertion failed (same cycle)");
// next-cycle implication
`define LSNA_ASSERT_NXT(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lsna assertion failed (next cycle)");
`else
`define LSNA_ASSERT_IMP(lbl, ck, rstn, ante, cons)
`define LSNA_ASSERT_NXT(lbl, ck, rstn, ante, cons)
`endif
`endif

### rtl/core/lsna_pkg.sv
// ----------------------------------------------------------------------------
// lsna_pkg
// Shared constants, neuron store entry and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package lsna_pkg;

    localparam int NEURONS_DEF = 1024;

    localparam int NEURON_W = 10;
    localparam int WEIGHT_W = 16;
    localparam int POT_W    = 32;
    localparam int THR_W    = 30;
    localparam int SHIFT_W  = 5;
    localparam int BAND_W   = 10;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 30;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND      = 2'd2;

    localparam logic [THR_W-1:0]   THR_RST   = 30'd500;
    localparam logic [SHIFT_W-1:0] SHIFT_RST = 5'd4;
    localparam logic [BAND_W-1:0]  BAND_RST  = 10'd5;

    typedef struct packed {
        logic              fired;
        logic              active;
        logic [POT_W-1:0]  pot;
    } entry_t;

    typedef struct packed {
        logic clear_wr;   // write a zero entry at the walk counter
        logic cnt_clr;
        logic cnt_inc;
        logic ev_load;    // capture event fields on transfer
        logic ev_commit;  // event read-modify-write and result
        logic walk_rd;    // tick walk: read entry at walk counter
        logic tick_done;  // tick result
    } cmd_t;

    typedef struct packed {
        logic cnt_last;
    } stat_t;

endpackage

`default_nettype wire

### rtl/core/lsna_ctrl.sv
// ----------------------------------------------------------------------------
// lsna_ctrl
// Sequencer: store clear after reset, event read-modify-write, tick walk.
// ----------------------------------------------------------------------------
`default_nettype none
`include "leaky_spiking_neuron_array_assert.svh"

module lsna_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic          mode,
    input  wire lsna_pkg::stat_t stat,
    output logic               busy,
    output lsna_pkg::cmd_t     cmd
);
    import lsna_pkg::*;

    localparam logic [2:0] ST_CLEAR    = 3'd0;
    localparam logic [2:0] ST_IDLE     = 3'd1;
    localparam logic [2:0] ST_EVENT    = 3'd2;
    localparam logic [2:0] ST_WALK     = 3'd3;
    localparam logic [2:0] ST_WALK_END = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                cmd.cnt_inc  = 1'b1;
                if (stat.cnt_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cmd.cnt_clr = 1'b1;
                if (start)
                begin
                    cmd.ev_load = 1'b1;
                    state_next  = mode ? ST_WALK : ST_EVENT;
                end
            end
            ST_EVENT:
            begin
                cmd.ev_commit = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_WALK:
            begin
                cmd.walk_rd = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (stat.cnt_last)
                begin
                    state_next = ST_WALK_END;
                end
            end
            ST_WALK_END:
            begin
                cmd.tick_done = 1'b1;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    `LSNA_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `LSNA_ASSERT_NXT(a_event_len, clk, rst_n, state_reg == ST_EVENT, state_reg == ST_IDLE)
    `LSNA_ASSERT_IMP(a_cmd_excl, clk, rst_n, busy, $onehot0({cmd.clear_wr, cmd.ev_commit, cmd.walk_rd}))

endmodule

`default_nettype wire

### rtl/core/lsna_dp.sv
// ----------------------------------------------------------------------------
// lsna_dp
// Neuron store, config registers, event and decay arithmetic, result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "leaky_spiking_neuron_array_assert.svh"

module lsna_dp #(
    parameter int NEURONS = lsna_pkg::NEURONS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire lsna_pkg::cmd_t                      cmd,
    output lsna_pkg::stat_t                          stat,
    input  wire logic [lsna_pkg::NEURON_W-1:0]       neuron,
    input  wire logic signed [lsna_pkg::WEIGHT_W-1:0] weight,
    input  wire logic                                wr_en,
    input  wire logic [lsna_pkg::CFG_IDX_W-1:0]      wr_index,
    input  wire logic [lsna_pkg::CFG_DATA_W-1:0]     wr_data,
    output logic                                     done,
    output logic                                     fired,
    output logic [lsna_pkg::NEURON_W-1:0]            spike_neuron
);
    import lsna_pkg::*;

    localparam int IDX_W = $clog2(NEURONS);

    // configuration
    logic [THR_W-1:0]   thr_reg;
    logic [SHIFT_W-1:0] shift_reg;
    logic [BAND_W-1:0]  band_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= THR_RST;
            shift_reg <= SHIFT_RST;
            band_reg  <= BAND_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                CFG_THRESHOLD: thr_reg   <= wr_data[THR_W-1:0];
                CFG_DECAY:     shift_reg <= wr_data[SHIFT_W-1:0];
                CFG_BAND:      band_reg  <= wr_data[BAND_W-1:0];
                default:       ;
            endcase
        end
    end

    // walk counter and tick write-back pipe
    logic [IDX_W-1:0] cnt_reg;
    logic [IDX_W-1:0] wb_addr_reg;
    logic             wb_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            wb_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cnt_clr)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            wb_vld_reg <= cmd.walk_rd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.walk_rd)
        begin
            wb_addr_reg <= cnt_reg;
        end
    end

    assign stat.cnt_last = (cnt_reg == IDX_W'(NEURONS - 1));

    // event capture
    logic [NEURON_W+IDX_W-1:0] nrn_ext;
    logic [IDX_W-1:0]          port_idx;
    logic                      port_ok;
    logic [IDX_W-1:0]          ev_idx_reg;
    logic [NEURON_W-1:0]       ev_nrn_reg;
    logic signed [WEIGHT_W-1:0] ev_w_reg;
    logic                      ev_ok_reg;

    assign nrn_ext  = {{IDX_W{1'b0}}, neuron};
    assign port_idx = nrn_ext[IDX_W-1:0];
    assign port_ok  = (32'(neuron) < 32'(NEURONS));

    always_ff @(posedge clk)
    begin
        if (cmd.ev_load)
        begin
            ev_idx_reg <= port_idx;
            ev_nrn_reg <= neuron;
            ev_w_reg   <= weight;
            ev_ok_reg  <= port_ok;
        end
    end

    // neuron store
    entry_t           mem [NEURONS];
    entry_t           rd_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    entry_t           mem_wdata;

    assign rd_addr = cmd.walk_rd ? cnt_reg : port_idx;

    always_ff @(posedge clk)
    begin
        rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    // event arithmetic
    logic signed [POT_W:0]   sum;
    logic signed [POT_W-1:0] v_sat;
    logic signed [POT_W-1:0] v_fire;
    logic                    fire;
    entry_t                  ev_entry;

    always_comb
    begin
        sum = {rd_reg.pot[POT_W-1], rd_reg.pot}
            + {{(POT_W + 1 - WEIGHT_W){ev_w_reg[WEIGHT_W-1]}}, ev_w_reg};
        if (sum[POT_W] != sum[POT_W-1])
        begin
            v_sat = sum[POT_W] ? {1'b1, {(POT_W-1){1'b0}}} : {1'b0, {(POT_W-1){1'b1}}};
        end
        else
        begin
            v_sat = sum[POT_W-1:0];
        end
        fire   = (v_sat > $signed({{(POT_W-THR_W){1'b0}}, thr_reg})) && !rd_reg.fired;
        // subtract twice the threshold
        v_fire = v_sat - $signed({{(POT_W-THR_W-1){1'b0}}, thr_reg, 1'b0});
        ev_entry.fired  = rd_reg.fired | fire;
        ev_entry.active = 1'b1;
        ev_entry.pot    = fire ? v_fire : v_sat;
    end

    // tick decay
    logic signed [POT_W-1:0] pot_s;
    logic signed [POT_W-1:0] band_s;
    logic signed [POT_W-1:0] dec;
    logic                    out_band;
    entry_t                  wk_entry;

    always_comb
    begin
        pot_s    = rd_reg.pot;
        band_s   = $signed({{(POT_W-BAND_W){1'b0}}, band_reg});
        out_band = (pot_s > band_s) || (pot_s < -band_s);
        dec      = pot_s - (pot_s >>> shift_reg);
        wk_entry.fired = 1'b0;
        if (!rd_reg.active)
        begin
            wk_entry.active = 1'b0;
            wk_entry.pot    = rd_reg.pot;
        end
        else if (out_band)
        begin
            wk_entry.active = 1'b1;
            wk_entry.pot    = dec;
        end
        else
        begin
            wk_entry.active = 1'b0;
            wk_entry.pot    = '0;
        end
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cnt_reg;
        mem_wdata = '0;
        priority if (cmd.clear_wr)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.ev_commit)
        begin
            mem_we    = ev_ok_reg;
            mem_waddr = ev_idx_reg;
            mem_wdata = ev_entry;
        end
        else if (wb_vld_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = wb_addr_reg;
            mem_wdata = wk_entry;
        end
    end

    // result register
    logic                done_reg;
    logic                fired_reg;
    logic [NEURON_W-1:0] spike_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg  <= 1'b0;
            fired_reg <= 1'b0;
            spike_reg <= '0;
        end
        else
        begin
            done_reg  <= cmd.ev_commit | cmd.tick_done;
            fired_reg <= cmd.ev_commit & ev_ok_reg & fire;
            spike_reg <= (cmd.ev_commit & ev_ok_reg & fire) ? ev_nrn_reg : '0;
        end
    end

    assign done         = done_reg;
    assign fired        = fired_reg;
    assign spike_neuron = spike_reg;

    `LSNA_ASSERT_NXT(a_done_strobe, clk, rst_n, done_reg, !done_reg)
    `LSNA_ASSERT_IMP(a_fired_done, clk, rst_n, fired_reg, done_reg)
    `LSNA_ASSERT_IMP(a_wb_walk_only, clk, rst_n, wb_vld_reg, !cmd.clear_wr && !cmd.ev_commit)

endmodule

`default_nettype wire

### rtl/core/leaky_spiking_neuron_array.sv
// Event: registered result strobe (done) after the EVENT state; next start once busy drops.
// Tick: walks the whole neuron store, one read and one write-back per cycle through the
//   single-port-read store; done is strobed after the WALK_END state, busy until then.
// Reset: config to defaults, then a store clearing pass over all NEURONS entries with busy high.
// Results are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
// leaky_spiking_neuron_array
// Leaky integrate-and-fire neuron array: synaptic events and decay ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module leaky_spiking_neuron_array #(
    parameter int NEURONS = lsna_pkg::NEURONS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic                                 mode,
    input  wire logic [lsna_pkg::NEURON_W-1:0]        neuron,
    input  wire logic signed [lsna_pkg::WEIGHT_W-1:0] weight,
    output logic                                      done,
    output logic                                      fired,
    output logic [lsna_pkg::NEURON_W-1:0]             spike_neuron,
    input  wire logic                                 wr_en,
    input  wire logic [lsna_pkg::CFG_IDX_W-1:0]       wr_index,
    input  wire logic [lsna_pkg::CFG_DATA_W-1:0]      wr_data
);
    import lsna_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    lsna_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (mode),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    lsna_dp #(
        .NEURONS (NEURONS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .neuron       (neuron),
        .weight       (weight),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .done         (done),
        .fired        (fired),
        .spike_neuron (spike_neuron)
    );

endmodule

`default_nettype wire
